// ----- rtl/fpa_pkg.sv -----
// Package: widths, operation codes and word types of the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 8;
    localparam int OP_W      = 4;

    // Divider: numerator is 2*|a|*2^FRAC_BITS + |b|, denominator is 2*|b|
    localparam int DQ_W = DATA_W + FRAC_BITS + 1;
    localparam int DD_W = DATA_W + 1;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Cycles from the queue head register to the result strobe
    localparam int BACK_LAT = DQ_W + 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MIN = 4'd4,
        OP_MAX = 4'd5,
        OP_INC = 4'd6,
        OP_DEC = 4'd7,
        OP_I2F = 4'd8,
        OP_F2I = 4'd9,
        OP_NONE = 4'd15
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     overflow;
        logic                     divide_by_zero;
    } t_res;

    // Classified word held in the queue
    typedef struct packed {
        t_op                      kind;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_qent;

    // Side data that rides along the divider stages
    typedef struct packed {
        logic                     vld;
        t_op                      kind;
        logic signed [DATA_W-1:0] res;
        logic                     ovf;
        logic                     lt;
        logic                     eq;
        logic                     gt;
        logic                     neg;
        logic                     dz;
    } t_side;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- rtl/fixed_point_q24_8_alu_core.sv -----
// Top level: signed Q24.8 fixed-point ALU with decoupled decode and execute.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+----------------------------------
//  command  | start, busy, i_cmd       | word taken when start && !busy
//  result   | o_valid, o_res           | one-cycle strobe, no back pressure
//
// One word may be taken every cycle. Each taken command walks the queue, the
// head register, stage B, the divider load register, the one-bit-per-stage
// restoring divider and the result register before its result strobe rises.
// Results leave in command order. Reset is synchronous and clears the
// queue and all valid flags; words in flight are dropped. busy rises only
// when the command queue is full, which cannot happen as the back end
// drains one word a cycle.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_core
    import fpa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_res o_res
);

    t_qstat qstat;
    t_qent  front_ent, head_ent;
    logic   push, pop;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_qstat (qstat),
        .o_push  (push),
        .o_ent   (front_ent)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (front_ent),
        .i_pop   (pop),
        .o_ent   (head_ent),
        .o_qstat (qstat)
    );

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_ent   (head_ent),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

// ----- rtl/fpa_front.sv -----
// Front end: command handshake and operation decode.
`timescale 1ns / 1ps
module fpa_front
    import fpa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_cmd   i_cmd,
    input  t_qstat i_qstat,
    output logic   o_push,
    output t_qent  o_ent
);

    // Hold off new commands only while the queue is full
    assign busy   = i_qstat.full;
    assign o_push = start && !i_qstat.full;

    // Decode the operation code; unused codes fall to the null kind
    always_comb begin
        o_ent.a = i_cmd.operand_a;
        o_ent.b = i_cmd.operand_b;
        unique case (i_cmd.operation)
            OP_ADD:  o_ent.kind = OP_ADD;
            OP_SUB:  o_ent.kind = OP_SUB;
            OP_MUL:  o_ent.kind = OP_MUL;
            OP_DIV:  o_ent.kind = OP_DIV;
            OP_MIN:  o_ent.kind = OP_MIN;
            OP_MAX:  o_ent.kind = OP_MAX;
            OP_INC:  o_ent.kind = OP_INC;
            OP_DEC:  o_ent.kind = OP_DEC;
            OP_I2F:  o_ent.kind = OP_I2F;
            OP_F2I:  o_ent.kind = OP_F2I;
            default: o_ent.kind = OP_NONE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qstat.full |-> !o_push) else $error("push into full queue");
`endif

endmodule

// ----- rtl/fpa_queue.sv -----
// Short command queue between front and back.
`timescale 1ns / 1ps
module fpa_queue
    import fpa_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_ent,
    input  logic   i_pop,
    output t_qent  o_ent,
    output t_qstat o_qstat
);

    t_qent            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_qstat.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_ent   = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + Q_AW'(1) : r_rd_ptr;
        n_count  = r_count + Q_CW'(do_push) - Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- rtl/fpa_back.sv -----
// Back end: arithmetic, multiplier, pipelined restoring divider and result register.
`timescale 1ns / 1ps
module fpa_back
    import fpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_qstat i_qstat,
    input  t_qent i_ent,
    output logic  o_pop,
    output logic  o_valid,
    output t_res  o_res
);

    localparam logic signed [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [2*DATA_W-1:0] HALF = (2*DATA_W)'(1) << (FRAC_BITS - 1);

    // Stage A: queue head register
    logic                     r_a_vld;
    t_qent                    r_a;

    // Stage B: simple results, product and divider operands
    t_side                    r_b;
    logic signed [2*DATA_W-1:0] r_b_prod;
    logic [DQ_W-1:0]          r_b_num;
    logic [DD_W-1:0]          r_b_den;

    // Divider stages
    t_side                    r_sd  [DQ_W+1];
    logic [DD_W-1:0]          r_rem [DQ_W+1];
    logic [DQ_W-1:0]          r_qn  [DQ_W+1];
    logic [DD_W-1:0]          r_den [DQ_W+1];

    logic                     r_out_vld;
    t_res                     r_out;

    // Drain the queue every cycle; the receiver never stalls
    assign o_pop = !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= i_ent;
    end

    // Stage B: add, sub, min, max, inc, dec, conversions, compares
    logic signed [DATA_W:0]   b_sum, b_dif;
    logic [DATA_W-1:0]        b_mag_a, b_mag_b;
    t_side                    n_b;

    always_comb begin
        b_sum   = {r_a.a[DATA_W-1], r_a.a} + {r_a.b[DATA_W-1], r_a.b};
        b_dif   = {r_a.a[DATA_W-1], r_a.a} - {r_a.b[DATA_W-1], r_a.b};
        b_mag_a = r_a.a[DATA_W-1] ? DATA_W'(-r_a.a) : DATA_W'(r_a.a);
        b_mag_b = r_a.b[DATA_W-1] ? DATA_W'(-r_a.b) : DATA_W'(r_a.b);
        n_b.vld  = r_a_vld;
        n_b.kind = r_a.kind;
        n_b.lt   = (r_a.a < r_a.b);
        n_b.eq   = (r_a.a == r_a.b);
        n_b.gt   = (r_a.a > r_a.b);
        n_b.neg  = r_a.a[DATA_W-1] ^ r_a.b[DATA_W-1];
        n_b.dz   = (r_a.b == '0);
        n_b.ovf  = 1'b0;
        n_b.res  = '0;
        unique case (r_a.kind)
            OP_ADD: begin
                n_b.ovf = (b_sum[DATA_W] != b_sum[DATA_W-1]);
                n_b.res = n_b.ovf ? (b_sum[DATA_W] ? MINV : MAXV) : b_sum[DATA_W-1:0];
            end
            OP_SUB: begin
                n_b.ovf = (b_dif[DATA_W] != b_dif[DATA_W-1]);
                n_b.res = n_b.ovf ? (b_dif[DATA_W] ? MINV : MAXV) : b_dif[DATA_W-1:0];
            end
            OP_MIN:  n_b.res = (r_a.a < r_a.b) ? r_a.a : r_a.b;
            OP_MAX:  n_b.res = (r_a.a > r_a.b) ? r_a.a : r_a.b;
            OP_INC:  n_b.res = r_a.a + DATA_W'(1);
            OP_DEC:  n_b.res = r_a.a - DATA_W'(1);
            OP_I2F:  n_b.res = r_a.a <<< FRAC_BITS;
            OP_F2I:  n_b.res = r_a.a >>> FRAC_BITS;
            default: n_b.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else begin
            r_b.vld <= n_b.vld;
        end
        r_b.kind <= n_b.kind;
        r_b.res  <= n_b.res;
        r_b.ovf  <= n_b.ovf;
        r_b.lt   <= n_b.lt;
        r_b.eq   <= n_b.eq;
        r_b.gt   <= n_b.gt;
        r_b.neg  <= n_b.neg;
        r_b.dz   <= n_b.dz;
        r_b_prod <= r_a.a * r_a.b;
        r_b_num  <= {b_mag_a, {(FRAC_BITS+1){1'b0}}} + DQ_W'(b_mag_b);
        r_b_den  <= {b_mag_b, 1'b0};
    end

    // Stage C: round and clamp the product, load the divider
    logic [2*DATA_W-1:0] c_pmag, c_m;
    t_side               n_c;

    always_comb begin
        c_pmag = r_b_prod[2*DATA_W-1] ? (2*DATA_W)'(-r_b_prod) : (2*DATA_W)'(r_b_prod);
        c_m    = (c_pmag + HALF) >> FRAC_BITS;
        n_c    = r_b;
        if (r_b.kind == OP_MUL) begin
            if (r_b.neg) begin
                n_c.ovf = (c_m > (2*DATA_W)'({1'b1, {(DATA_W-1){1'b0}}}));
                n_c.res = n_c.ovf ? MINV : DATA_W'(-c_m);
            end else begin
                n_c.ovf = (c_m > (2*DATA_W)'(MAXV));
                n_c.res = n_c.ovf ? MAXV : c_m[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd[0].vld <= 1'b0;
        end else begin
            r_sd[0].vld <= n_c.vld;
        end
        r_sd[0].kind <= n_c.kind;
        r_sd[0].res  <= n_c.res;
        r_sd[0].ovf  <= n_c.ovf;
        r_sd[0].lt   <= n_c.lt;
        r_sd[0].eq   <= n_c.eq;
        r_sd[0].gt   <= n_c.gt;
        r_sd[0].neg  <= n_c.neg;
        r_sd[0].dz   <= n_c.dz;
        r_rem[0]     <= '0;
        r_qn[0]      <= r_b_num;
        r_den[0]     <= r_b_den;
    end

    // Divider: one quotient bit per stage
    for (genvar k = 1; k <= DQ_W; k++) begin : g_div
        logic [DD_W:0] s_try;
        logic          s_ge;

        always_comb begin
            s_try = {r_rem[k-1], r_qn[k-1][DQ_W-1]};
            s_ge  = (s_try >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sd[k].vld <= 1'b0;
            end else begin
                r_sd[k].vld <= r_sd[k-1].vld;
            end
            r_sd[k].kind <= r_sd[k-1].kind;
            r_sd[k].res  <= r_sd[k-1].res;
            r_sd[k].ovf  <= r_sd[k-1].ovf;
            r_sd[k].lt   <= r_sd[k-1].lt;
            r_sd[k].eq   <= r_sd[k-1].eq;
            r_sd[k].gt   <= r_sd[k-1].gt;
            r_sd[k].neg  <= r_sd[k-1].neg;
            r_sd[k].dz   <= r_sd[k-1].dz;
            r_rem[k]     <= s_ge ? DD_W'(s_try - {1'b0, r_den[k-1]}) : s_try[DD_W-1:0];
            r_qn[k]      <= {r_qn[k-1][DQ_W-2:0], s_ge};
            r_den[k]     <= r_den[k-1];
        end
    end

    // Output: clamp the quotient and register the result word
    logic [DQ_W-1:0] o_q;
    t_side           o_sd;
    t_res            n_out;

    always_comb begin
        o_q  = r_qn[DQ_W];
        o_sd = r_sd[DQ_W];
        n_out.result_value   = o_sd.res;
        n_out.overflow       = o_sd.ovf;
        n_out.divide_by_zero = 1'b0;
        n_out.a_less         = o_sd.lt;
        n_out.a_equal        = o_sd.eq;
        n_out.a_greater      = o_sd.gt;
        if (o_sd.kind == OP_DIV) begin
            if (o_sd.dz) begin
                n_out.result_value   = '0;
                n_out.overflow       = 1'b0;
                n_out.divide_by_zero = 1'b1;
            end else if (o_sd.neg) begin
                n_out.overflow     = (o_q > DQ_W'({1'b1, {(DATA_W-1){1'b0}}}));
                n_out.result_value = n_out.overflow ? MINV : DATA_W'(-o_q);
            end else begin
                n_out.overflow     = (o_q > DQ_W'(MAXV));
                n_out.result_value = n_out.overflow ? MAXV : o_q[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= o_sd.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> ##(BACK_LAT) o_valid) else $error("result strobe missing");
    a_dz_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.divide_by_zero |-> o_res.result_value == '0 && !o_res.overflow)
        else $error("divide by zero result not clean");
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_res.a_less, o_res.a_equal, o_res.a_greater}))
        else $error("compare flags not one-hot");
`endif

endmodule
